/* hdl/pec_pkg.sv */
// Package: shared types and constants of the pixel exposure compensation block
`default_nettype none

package pec_pkg;

  // Field widths
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned SLOT_W      = 8;
  localparam int unsigned VALUE_W     = 48;
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned EXP_W       = 32;   // Q16.16 exposure
  localparam int unsigned RATIO_W     = 24;   // Q8.16 exposure ratio
  localparam int unsigned RATIO_FRAC  = 16;
  localparam int unsigned SCALED_W    = EXP_W + RATIO_W - RATIO_FRAC;
  localparam int unsigned ACC_W       = 64;   // Horner accumulator, Q.32
  localparam int unsigned COUNT_W     = 4;

  // Exposure table
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned TABLE_AW    = 8;
  localparam logic [TABLE_AW-1:0] TABLE_FIRST = '0;
  localparam logic [TABLE_AW-1:0] TABLE_LAST  = TABLE_AW'(TABLE_DEPTH - 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(65536);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

  // Saturation limits and output range
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_TOP = {24'd0, 8'd255, 32'd0};
  localparam logic [ACC_W-1:0]        ACC_HALF = {32'd0, 1'b1, 31'd0};
  localparam logic [PIX_W-1:0]        PIX_MAX  = '1;

  // Input item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TABLE = 2'd0,
    KIND_COEF  = 2'd1,
    KIND_PIXEL = 2'd2
  } item_kind_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPOSURE_RATIO    = 2'd0,
    CFG_COEFFICIENT_COUNT = 2'd1
  } cfg_reg_e;

  // Input item
  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [SLOT_W-1:0]         slot;
    logic signed [VALUE_W-1:0] load_value;
    logic [PIX_W-1:0]          pixel_in;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             exposure_clamped;
    logic             intensity_clamped;
  } out_item_t;

  // Item as it travels down the cell chain
  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [SLOT_W-1:0]         slot;
    logic signed [VALUE_W-1:0] value;
    logic [EXP_W-1:0]          x;
    logic                      eflag;
    logic signed [ACC_W-1:0]   acc;
  } pipe_t;

endpackage

`default_nettype wire

/* hdl/pec_front.sv */
// Front end: exposure table memory, exposure scaling and clamping
`default_nettype none

module pec_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      adv_i,
  input  wire logic                      in_vld_i,
  input  wire pec_pkg::in_item_t         in_item_i,
  input  wire logic [pec_pkg::RATIO_W-1:0] ratio_i,
  output logic                           vld_o,
  output pec_pkg::pipe_t                 item_o
);
  import pec_pkg::*;

  logic [EXP_W-1:0] table_mem [TABLE_DEPTH];
  logic [EXP_W-1:0] bound_lo_q, bound_hi_q;
  logic             accept;
  logic             table_wr;

  logic                      v0_q, v1_q, v2_q;
  logic [KIND_W-1:0]         kind0_q, kind1_q;
  logic [SLOT_W-1:0]         slot0_q, slot1_q;
  logic signed [VALUE_W-1:0] value0_q, value1_q;
  logic [EXP_W-1:0]          lo0_q, hi0_q, lo1_q, hi1_q;
  logic [EXP_W-1:0]          rd0_q;
  logic [SCALED_W-1:0]       e1_q;
  logic [EXP_W+RATIO_W-1:0]  scale_prod;
  pipe_t                     f2_d, f2_q;

  assign accept   = in_vld_i && adv_i;
  assign table_wr = accept && (in_item_i.kind == KIND_TABLE);

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (table_wr) begin
      table_mem[in_item_i.slot] <= in_item_i.load_value[EXP_W-1:0];
    end
    if (adv_i) begin
      rd0_q <= table_mem[in_item_i.pixel_in];
    end
  end

  // Shadow copies of the first and last entries for the clamp bounds
  always_ff @(posedge clk_i) begin
    if (table_wr && (in_item_i.slot == TABLE_FIRST)) begin
      bound_lo_q <= in_item_i.load_value[EXP_W-1:0];
    end
    if (table_wr && (in_item_i.slot == TABLE_LAST)) begin
      bound_hi_q <= in_item_i.load_value[EXP_W-1:0];
    end
  end

  // Valid bits of the three front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v0_q <= in_vld_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  // Scaled exposure, truncated Q24.16
  assign scale_prod = rd0_q * ratio_i;

  // Clamp to the table range; upper bound is tested first
  always_comb begin
    f2_d       = '0;
    f2_d.kind  = kind1_q;
    f2_d.slot  = slot1_q;
    f2_d.value = value1_q;
    f2_d.acc   = '0;
    if (e1_q > {{(SCALED_W-EXP_W){1'b0}}, hi1_q}) begin
      f2_d.x     = hi1_q;
      f2_d.eflag = 1'b1;
    end else if (e1_q < {{(SCALED_W-EXP_W){1'b0}}, lo1_q}) begin
      f2_d.x     = lo1_q;
      f2_d.eflag = 1'b1;
    end else begin
      f2_d.x     = e1_q[EXP_W-1:0];
      f2_d.eflag = 1'b0;
    end
  end

  // Payload of the front stages
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      kind0_q  <= in_item_i.kind;
      slot0_q  <= in_item_i.slot;
      value0_q <= in_item_i.load_value;
      lo0_q    <= bound_lo_q;
      hi0_q    <= bound_hi_q;
      kind1_q  <= kind0_q;
      slot1_q  <= slot0_q;
      value1_q <= value0_q;
      lo1_q    <= lo0_q;
      hi1_q    <= hi0_q;
      e1_q     <= scale_prod[EXP_W+RATIO_W-1:RATIO_FRAC];
      f2_q     <= f2_d;
    end
  end

  assign vld_o  = v2_q;
  assign item_o = f2_q;

endmodule

`default_nettype wire

/* hdl/pec_cell.sv */
// Horner cell: holds one coefficient and does one multiply-add step
`default_nettype none

module pec_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  wire logic           active_i,
  input  wire logic           vld_i,
  input  wire pec_pkg::pipe_t item_i,
  output logic                vld_o,
  output pec_pkg::pipe_t      item_o
);
  import pec_pkg::*;

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_IDX);

  logic signed [VALUE_W-1:0] coef_q;

  logic                    a_vld_q, b_vld_q, c_vld_q;
  pipe_t                   a_item_q, b_item_q, c_item_q, c_item_d;
  logic                    a_neg_q;
  logic [31:0]             a_mag_hi_q;
  logic [47:0]             a_lo_sh_q;
  logic signed [ACC_W-1:0] b_prod_q, b_prod_d;

  logic                    neg;
  logic [ACC_W-1:0]        mag;
  logic [63:0]             lo_prod;
  logic [63:0]             hi_prod;
  logic                    over;
  logic [ACC_W-1:0]        mag_r;
  logic signed [ACC_W-1:0] coef_ext;
  logic signed [ACC_W-1:0] sum;
  logic                    sum_ovf;
  logic signed [ACC_W-1:0] step;

  // Stage A: magnitude and low partial product
  assign neg     = item_i.acc[ACC_W-1];
  assign mag     = neg ? (ACC_W'(0) - $unsigned(item_i.acc)) : $unsigned(item_i.acc);
  assign lo_prod = mag[31:0] * item_i.x;

  // Stage B: high partial product, shift by 16, saturate
  assign hi_prod = a_mag_hi_q * a_item_q.x;
  assign over    = |hi_prod[63:47];
  assign mag_r   = {hi_prod[47:0], 16'd0} + {16'd0, a_lo_sh_q};

  always_comb begin
    if (a_neg_q) begin
      b_prod_d = (over || mag_r[ACC_W-1]) ? ACC_MIN : $signed(ACC_W'(0) - mag_r);
    end else begin
      b_prod_d = (over || mag_r[ACC_W-1]) ? ACC_MAX : $signed(mag_r);
    end
  end

  // Stage C: saturating add of this cell's coefficient
  assign coef_ext = {{(ACC_W-VALUE_W){coef_q[VALUE_W-1]}}, coef_q};
  assign sum      = b_prod_q + coef_ext;
  assign sum_ovf  = (b_prod_q[ACC_W-1] == coef_ext[ACC_W-1]) &&
                    (sum[ACC_W-1] != b_prod_q[ACC_W-1]);
  assign step     = sum_ovf ? (b_prod_q[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum;

  always_comb begin
    c_item_d = b_item_q;
    if (active_i) begin
      c_item_d.acc = step;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (adv_i) begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_item_q   <= item_i;
      a_neg_q    <= neg;
      a_mag_hi_q <= mag[63:32];
      a_lo_sh_q  <= lo_prod[63:16];
      b_item_q   <= a_item_q;
      b_prod_q   <= b_prod_d;
      c_item_q   <= c_item_d;
    end
  end

  // Coefficient load takes effect where a pixel would read it, keeping item order
  always_ff @(posedge clk_i) begin
    if (adv_i && b_vld_q && (b_item_q.kind == KIND_COEF) && (b_item_q.slot == MY_SLOT)) begin
      coef_q <= b_item_q.value;
    end
  end

  assign vld_o  = c_vld_q;
  assign item_o = c_item_q;

endmodule

`default_nettype wire

/* hdl/pixel_exposure_compensation_top.sv */
// Top level: exposure compensation through a chain of Horner cells
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------
//  in      | in_valid_i / in_stall_o    | in_item_i  (in_item_t)
//  out     | out_valid_o / out_stall_i  | out_item_o (out_item_t)
//  cfg     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One item enters per cycle while the output is not stalled; every item runs
// the whole chain: three front stages, three stages per Horner cell
// (two 32x32 partial products, then the add) and the output register.
// A stalled output freezes the whole chain. Reset clears valid bits and
// config; table and coefficients hold nothing until loaded.
`default_nettype none

module pixel_exposure_compensation_top #(
  parameter int unsigned MAX_COEFFICIENTS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire pec_pkg::in_item_t              in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output pec_pkg::out_item_t                  out_item_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [pec_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [pec_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pec_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_COEFFICIENTS + 1) + COUNT_W;

  logic [RATIO_W-1:0] ratio_q;
  logic [COUNT_W-1:0] count_q;
  logic               adv;

  logic  chain_vld  [MAX_COEFFICIENTS+1];
  pipe_t chain_item [MAX_COEFFICIENTS+1];

  pipe_t     last_item;
  logic      out_vld_q;
  out_item_t out_q, out_d;

  // Whole pipeline moves unless a finished result is held up
  assign adv         = !(out_vld_q && out_stall_i);
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RATIO_RESET;
      count_q <= COUNT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_EXPOSURE_RATIO:    ratio_q <= cfg_data_i[RATIO_W-1:0];
        CFG_COEFFICIENT_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  pec_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .in_vld_i  (in_valid_i),
    .in_item_i (in_item_i),
    .ratio_i   (ratio_q),
    .vld_o     (chain_vld[0]),
    .item_o    (chain_item[0])
  );

  // Row of Horner cells; cell 0 starts from zero so it just loads coefficient 0
  for (genvar i = 0; i < MAX_COEFFICIENTS; i++) begin : g_cell
    logic active;
    assign active = (i == 0) || (IDX_W'(i) < IDX_W'(count_q));

    pec_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .active_i (active),
      .vld_i    (chain_vld[i]),
      .item_i   (chain_item[i]),
      .vld_o    (chain_vld[i+1]),
      .item_o   (chain_item[i+1])
    );
  end

  assign last_item = chain_item[MAX_COEFFICIENTS];

  // Clamp to 0..255 and round half up
  always_comb begin
    logic [ACC_W-1:0] rnd;
    rnd = $unsigned(last_item.acc) + ACC_HALF;
    out_d.exposure_clamped = last_item.eflag;
    if (last_item.acc[ACC_W-1]) begin
      out_d.pixel_out         = '0;
      out_d.intensity_clamped = 1'b1;
    end else if (last_item.acc > ACC_TOP) begin
      out_d.pixel_out         = PIX_MAX;
      out_d.intensity_clamped = 1'b1;
    end else begin
      out_d.pixel_out         = rnd[32+PIX_W-1:32];
      out_d.intensity_clamped = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= chain_vld[MAX_COEFFICIENTS] && (last_item.kind == KIND_PIXEL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire
